// ===== rtl/work_partition_rank_calc_macros.svh =====
// Assertion macros shared by the work partition RTL.
// Expects clk and rst_n in scope at the point of use.
`ifndef WORK_PARTITION_RANK_CALC_MACROS_SVH
`define WORK_PARTITION_RANK_CALC_MACROS_SVH

// same-cycle implication
`define WPRC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wprc assertion failed");

// next-cycle implication
`define WPRC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wprc assertion failed");

`endif

// ===== rtl/wprc_pkg.sv =====
// Shared types and constants for the work partition rank calculator.
// No dependencies.
`timescale 1ns / 1ps

package wprc_pkg;

    localparam int unsigned MAX_WORKERS = 1024;
    localparam int unsigned DIV_STAGES  = 16;

    // configuration register indexes
    localparam logic [1:0] REG_ITEM_COUNT  = 2'd0;
    localparam logic [1:0] REG_THREADS     = 2'd1;
    localparam logic [1:0] REG_ROOT_IDLE   = 2'd2;
    localparam logic [1:0] REG_WORKER_CNT  = 2'd3;

    typedef enum logic [2:0] {
        CS_START,
        CS_DIV_GS,
        CS_DIV_GC,
        CS_DIV_SPP,
        CS_MUL,
        CS_FIN,
        CS_IDLE
    } cfg_state_t;

    // values that follow from the configuration alone
    typedef struct packed {
        logic        busy;
        logic [10:0] gs;
        logic [9:0]  gc;
        logic        root_act;
        logic [15:0] spp;
        logic [15:0] root_sh;
        logic [15:0] base;      // item count minus root share
    } cfg_derived_t;

    // per-transaction data that rides beside the dividers
    typedef struct packed {
        logic        rank_pos;
        logic        owner0;
        logic [25:0] prod_first;
        logic [20:0] first_child;
    } side_t;

endpackage

// ===== rtl/work_partition_rank_calc.sv =====
// Pipeline from input transaction to result: entry stage, 16 divide stages, output stage.
// Throughput: one transaction per cycle while in_ready; all stages stall on out_ready.
// After a config write or reset the derive sequencer steps through start, three serial
// 17-step divisions, multiply and finish; in_ready and cfg_ready stay low meanwhile.
// Reset (rst_n, async low) clears valid bits and loads default register values.
// Top level of the work partition calculator; depends on wprc_pkg and its submodules.
`timescale 1ns / 1ps
`include "work_partition_rank_calc_macros.svh"

module work_partition_rank_calc (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [9:0]  worker_rank,
    input  logic [10:0] query_group,
    input  logic [15:0] item_id,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [10:0] group_size,
    output logic [9:0]  group_count,
    output logic [10:0] group_number,
    output logic        root_active,
    output logic [9:0]  active_rank,
    output logic [15:0] items_per_worker,
    output logic [15:0] root_share,
    output logic [15:0] first_item,
    output logic [15:0] own_item_count,
    output logic [20:0] owner_rank
);

    localparam int unsigned NS = wprc_pkg::DIV_STAGES;

    wprc_pkg::cfg_derived_t drv;

    logic en;
    logic [NS:0]  vld_reg;
    logic [15:0]  rem1 [NS+1];
    logic [15:0]  dq1  [NS+1];
    logic [15:0]  rem2 [NS+1];
    logic [15:0]  dq2  [NS+1];
    wprc_pkg::side_t sb_reg [NS+1];

    // entry stage
    logic [10:0] qg;
    logic        use_root;
    logic        below_root;
    logic [15:0] n_calc;
    logic [9:0]  rank_m1;
    logic [21:0] fc_prod;
    wprc_pkg::side_t sb_next;

    // final stage
    logic [10:0] grp;
    logic [10:0] r1_inc;
    logic [9:0]  act;
    logic [10:0] p;
    logic [15:0] diff_own;
    logic [15:0] own;
    logic [15:0] first;
    logic [20:0] owner;
    logic        out_valid_reg;
    logic [10:0] grp_reg;
    logic [9:0]  act_reg;
    logic [15:0] first_reg;
    logic [15:0] own_reg;
    logic [20:0] owner_reg;

    wprc_cfg_calc u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .drv       (drv)
    );

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en && !drv.busy;

    always_comb
    begin
        qg         = (query_group == 11'd0) ? 11'd1 : query_group;
        use_root   = (qg == 11'(drv.gc)) && drv.root_act;
        below_root = item_id < drv.root_sh;
        n_calc     = use_root ? item_id - drv.root_sh : item_id;
        rank_m1    = worker_rank - 10'd1;
        fc_prod    = 22'(qg - 11'd1) * 22'(drv.gs) + 22'd1;

        sb_next.rank_pos    = (worker_rank != 10'd0);
        sb_next.owner0      = use_root && below_root;
        sb_next.prod_first  = 26'(drv.spp) * 26'(rank_m1);
        sb_next.first_child = fc_prod[20:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[NS-1:0], in_valid && !drv.busy};
            out_valid_reg <= vld_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem1[0]   <= '0;
            dq1[0]    <= 16'(rank_m1);
            rem2[0]   <= '0;
            dq2[0]    <= n_calc;
            sb_reg[0] <= sb_next;
            for (int i = 1; i <= NS; i++)
                sb_reg[i] <= sb_reg[i-1];
        end
    end

    for (genvar k = 0; k < NS; k++)
    begin : g_div
        wprc_div_stage u_grp (
            .clk     (clk),
            .en      (en),
            .divisor (16'(drv.gs)),
            .rem_in  (rem1[k]),
            .dq_in   (dq1[k]),
            .rem_out (rem1[k+1]),
            .dq_out  (dq1[k+1])
        );
        wprc_div_stage u_own (
            .clk     (clk),
            .en      (en),
            .divisor (drv.spp),
            .rem_in  (rem2[k]),
            .dq_in   (dq2[k]),
            .rem_out (rem2[k+1]),
            .dq_out  (dq2[k+1])
        );
    end

    always_comb
    begin
        grp    = sb_reg[NS].rank_pos ? dq1[NS][10:0] + 11'd1 : 11'(drv.gc);
        r1_inc = rem1[NS][10:0] + 11'd1;
        if (!sb_reg[NS].rank_pos)
            act = '0;
        else if (grp < 11'(drv.gc) || !drv.root_act)
            act = rem1[NS][9:0];
        else
            act = (r1_inc == drv.gs) ? 10'd0 : r1_inc[9:0];

        // last worker of the group takes what is left
        if (drv.spp == 16'd0 || dq2[NS] >= 16'(drv.gs))
            p = drv.gs - 11'd1;
        else
            p = dq2[NS][10:0];
        owner = sb_reg[NS].owner0 ? 21'd0 : sb_reg[NS].first_child + 21'(p);

        diff_own = drv.base - sb_reg[NS].prod_first[15:0];
        if (sb_reg[NS].rank_pos)
        begin
            if (sb_reg[NS].prod_first >= 26'(drv.base))
            begin
                own   = '0;
                first = '0;
            end
            else
            begin
                own   = (diff_own > drv.spp) ? drv.spp : diff_own;
                first = drv.root_sh + sb_reg[NS].prod_first[15:0];
            end
        end
        else
        begin
            own   = (drv.root_sh > drv.spp) ? drv.spp : drv.root_sh;
            first = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            grp_reg   <= grp;
            act_reg   <= act;
            first_reg <= first;
            own_reg   <= own;
            owner_reg <= owner;
        end
    end

    assign out_valid        = out_valid_reg;
    assign group_size       = drv.gs;
    assign group_count      = drv.gc;
    assign group_number     = grp_reg;
    assign root_active      = drv.root_act;
    assign active_rank      = act_reg;
    assign items_per_worker = drv.spp;
    assign root_share       = drv.root_sh;
    assign first_item       = first_reg;
    assign own_item_count   = own_reg;
    assign owner_rank       = owner_reg;

    `WPRC_ASSERT_NOW(a_busy_blocks_in, drv.busy, !in_ready)
    `WPRC_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, vld_reg[0])
    `WPRC_ASSERT_NEXT(a_stall_freezes, !en, $stable(vld_reg))
    `WPRC_ASSERT_NOW(a_no_busy_in_flight, drv.busy, vld_reg == '0 && !out_valid_reg)

endmodule

// ===== rtl/wprc_div_stage.sv =====
// One restoring division step, registered: one quotient bit per stage.
// No package dependency.
`timescale 1ns / 1ps

module wprc_div_stage (
    input  logic        clk,
    input  logic        en,
    input  logic [15:0] divisor,
    input  logic [15:0] rem_in,
    input  logic [15:0] dq_in,
    output logic [15:0] rem_out,
    output logic [15:0] dq_out
);

    logic [16:0] shifted;
    logic        ge;
    logic [16:0] diff;
    logic [15:0] rem_next;
    logic [15:0] dq_next;
    logic [15:0] rem_reg;
    logic [15:0] dq_reg;

    always_comb
    begin
        shifted  = {rem_in, dq_in[15]};
        ge       = shifted >= {1'b0, divisor};
        diff     = shifted - {1'b0, divisor};
        rem_next = ge ? diff[15:0] : shifted[15:0];
        dq_next  = {dq_in[14:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            dq_reg  <= dq_next;
        end
    end

    assign rem_out = rem_reg;
    assign dq_out  = dq_reg;

endmodule

// ===== rtl/wprc_cfg_calc.sv =====
// Configuration registers and the sequencer that derives group layout from them.
// Depends on wprc_pkg; uses one shared bit-serial divider.
`timescale 1ns / 1ps

module wprc_cfg_calc (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    output wprc_pkg::cfg_derived_t drv
);

    localparam logic [4:0] DIV_LAST = 5'd16;

    wprc_pkg::cfg_state_t state_reg, state_next;

    logic [15:0] item_count_reg;
    logic [8:0]  threads_reg;
    logic        root_idle_reg;
    logic [10:0] worker_count_reg;

    logic [10:0] rem_reg, rem_next;
    logic [16:0] dq_reg, dq_next;
    logic [10:0] dvs_reg, dvs_next;
    logic [4:0]  cnt_reg, cnt_next;

    logic [10:0] gs_reg, gs_next;
    logic [9:0]  gc_reg, gc_next;
    logic [15:0] spp_reg, spp_next;
    logic [20:0] prod_gc_reg, prod_gc_next;
    logic [25:0] prod_sh_reg, prod_sh_next;
    logic        root_act_reg, root_act_next;
    logic [15:0] root_sh_reg, root_sh_next;
    logic [15:0] base_reg, base_next;

    logic [8:0]  thr;
    logic [10:0] wc;
    logic [10:0] usable;
    logic [11:0] shifted;
    logic        ge;
    logic [11:0] sub;
    logic [16:0] q;
    logic        last;

    assign cfg_ready = (state_reg == wprc_pkg::CS_IDLE);

    always_comb
    begin
        thr = (threads_reg == 9'd0) ? 9'd1 : threads_reg;
        if (worker_count_reg == 11'd0)
            wc = 11'd1;
        else if (worker_count_reg > 11'(wprc_pkg::MAX_WORKERS))
            wc = 11'(wprc_pkg::MAX_WORKERS);
        else
            wc = worker_count_reg;
        usable = (root_idle_reg && wc > 11'd1) ? wc - 11'd1 : wc;

        shifted = {rem_reg, dq_reg[16]};
        ge      = shifted >= {1'b0, dvs_reg};
        sub     = shifted - {1'b0, dvs_reg};
        q       = {dq_reg[15:0], ge};
        last    = (cnt_reg == DIV_LAST);
    end

    always_comb
    begin
        state_next    = state_reg;
        rem_next      = ge ? sub[10:0] : shifted[10:0];
        dq_next       = q;
        dvs_next      = dvs_reg;
        cnt_next      = cnt_reg + 5'd1;
        gs_next       = gs_reg;
        gc_next       = gc_reg;
        spp_next      = spp_reg;
        prod_gc_next  = 21'(gs_reg) * 21'(gc_reg);
        prod_sh_next  = 26'(spp_reg) * 26'(wc - 11'd1);
        root_act_next = root_act_reg;
        root_sh_next  = root_sh_reg;
        base_next     = base_reg;
        unique case (state_reg)
            wprc_pkg::CS_START:
            begin
                rem_next   = '0;
                dq_next    = {1'b0, item_count_reg} + 17'(thr) - 17'd1;
                dvs_next   = 11'(thr);
                cnt_next   = '0;
                state_next = wprc_pkg::CS_DIV_GS;
            end
            wprc_pkg::CS_DIV_GS:
            begin
                if (last)
                begin
                    if (q == 17'd0)
                        gs_next = 11'd1;
                    else if (q > 17'(usable))
                        gs_next = usable;
                    else
                        gs_next = q[10:0];
                    rem_next   = '0;
                    dq_next    = 17'(wc - 11'd1);
                    dvs_next   = gs_next;
                    cnt_next   = '0;
                    state_next = wprc_pkg::CS_DIV_GC;
                end
            end
            wprc_pkg::CS_DIV_GC:
            begin
                if (last)
                begin
                    gc_next    = (q == 17'd0) ? 10'd1 : q[9:0];
                    rem_next   = '0;
                    dq_next    = {1'b0, item_count_reg} + 17'(gs_reg) - 17'd1;
                    dvs_next   = gs_reg;
                    cnt_next   = '0;
                    state_next = wprc_pkg::CS_DIV_SPP;
                end
            end
            wprc_pkg::CS_DIV_SPP:
            begin
                if (last)
                begin
                    if (q < 17'(thr))
                        spp_next = 16'(thr);
                    else
                        spp_next = q[15:0];
                    if (q > 17'(item_count_reg) || 17'(spp_next) > 17'(item_count_reg))
                        spp_next = item_count_reg;
                    state_next = wprc_pkg::CS_MUL;
                end
            end
            wprc_pkg::CS_MUL:
            begin
                state_next = wprc_pkg::CS_FIN;
            end
            wprc_pkg::CS_FIN:
            begin
                root_act_next = (wc == 11'd1) ||
                    (!root_idle_reg && gs_reg > 11'd1 && 21'(wc) <= prod_gc_reg);
                if (root_idle_reg || 26'(item_count_reg) <= prod_sh_reg)
                    root_sh_next = '0;
                else
                    root_sh_next = item_count_reg - prod_sh_reg[15:0];
                base_next  = item_count_reg - root_sh_next;
                state_next = wprc_pkg::CS_IDLE;
            end
            wprc_pkg::CS_IDLE:
            begin
                if (cfg_valid)
                    state_next = wprc_pkg::CS_START;
            end
            default:
            begin
                state_next = wprc_pkg::CS_START;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= wprc_pkg::CS_START;
            item_count_reg   <= 16'd1;
            threads_reg      <= 9'd1;
            root_idle_reg    <= 1'b0;
            worker_count_reg <= 11'd1;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    wprc_pkg::REG_ITEM_COUNT: item_count_reg   <= cfg_data;
                    wprc_pkg::REG_THREADS:    threads_reg      <= cfg_data[8:0];
                    wprc_pkg::REG_ROOT_IDLE:  root_idle_reg    <= cfg_data[0];
                    wprc_pkg::REG_WORKER_CNT: worker_count_reg <= cfg_data[10:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        dq_reg       <= dq_next;
        dvs_reg      <= dvs_next;
        cnt_reg      <= cnt_next;
        gs_reg       <= gs_next;
        gc_reg       <= gc_next;
        spp_reg      <= spp_next;
        prod_gc_reg  <= prod_gc_next;
        prod_sh_reg  <= prod_sh_next;
        root_act_reg <= root_act_next;
        root_sh_reg  <= root_sh_next;
        base_reg     <= base_next;
    end

    always_comb
    begin
        drv.busy     = (state_reg != wprc_pkg::CS_IDLE);
        drv.gs       = gs_reg;
        drv.gc       = gc_reg;
        drv.root_act = root_act_reg;
        drv.spp      = spp_reg;
        drv.root_sh  = root_sh_reg;
        drv.base     = base_reg;
    end

endmodule

// ===== tb/tb_top.sv =====
// Testbench for work_partition_rank_calc: directed and random queries checked against
// an in-bench partition predictor. Depends on wprc_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_top;

    localparam int HOLD_CYCLES = 200;
    localparam int TAIL_CYCLES = 40;
    localparam longint LIMIT = 400000;

    typedef struct packed {
        logic [10:0] gs;
        logic [9:0]  gc;
        logic [10:0] grp;
        logic        ract;
        logic [9:0]  arank;
        logic [15:0] spp;
        logic [15:0] rsh;
        logic [15:0] first;
        logic [15:0] own;
        logic [20:0] owner;
    } layout_t;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic in_valid = 0;
    logic in_ready;
    logic [9:0] worker_rank = '0;
    logic [10:0] query_group = '0;
    logic [15:0] item_id = '0;
    logic out_valid;
    logic out_ready = 0;
    logic [10:0] group_size;
    logic [9:0] group_count;
    logic [10:0] group_number;
    logic root_active;
    logic [9:0] active_rank;
    logic [15:0] items_per_worker;
    logic [15:0] root_share;
    logic [15:0] first_item;
    logic [15:0] own_item_count;
    logic [20:0] owner_rank;

    // shadow of the configuration registers
    longint sh_items = 1, sh_thr = 1, sh_idle = 0, sh_wc = 1;

    layout_t expected_layouts[$];
    int errors = 0;
    longint cycles = 0;
    bit hold_off = 0;
    bit burst_mode = 1;

    always #5 clk = ~clk;

    work_partition_rank_calc DUT (.*);

    function automatic layout_t predict_layout(logic [9:0] r, logic [10:0] qg, logic [15:0] id);
        longint items, thr, wc, rank, q, iid, usable, gs, gc, grp, ar, spp, rsh;
        longint first, own, fc, n, p, owner;
        bit idle, ract, use_root;
        layout_t l;
        items = sh_items;
        thr = sh_thr;
        wc = sh_wc;
        idle = sh_idle != 0;
        rank = longint'(r);
        q = longint'(qg);
        iid = longint'(id);
        if (thr < 1) thr = 1;
        if (wc < 1) wc = 1;
        if (wc > longint'(wprc_pkg::MAX_WORKERS)) wc = longint'(wprc_pkg::MAX_WORKERS);
        if (q < 1) q = 1;
        usable = (idle && wc > 1) ? wc - 1 : wc;
        gs = (items + thr - 1) / thr;
        if (gs < 1) gs = 1;
        if (gs > usable) gs = usable;
        gc = (wc - 1) / gs;
        if (gc < 1) gc = 1;
        grp = (rank > 0) ? 1 + (rank - 1) / gs : gc;
        ract = (wc == 1) || (!idle && gs > 1 && wc <= gs * gc);
        ar = (rank > 0 && (!(grp >= gc) || !ract)) ? (rank - 1) % gs : rank % gs;
        spp = (items + gs - 1) / gs;
        if (spp < thr) spp = thr;
        if (spp > items) spp = items;
        rsh = 0;
        if (!idle)
        begin
            rsh = items - spp * (wc - 1);
            if (rsh < 0) rsh = 0;
        end
        first = 0;
        own = rsh;
        if (rank > 0)
        begin
            first = rsh + spp * (rank - 1);
            own = items - first;
            if (own <= 0) first = 0;
        end
        if (own < 0) own = 0;
        if (own > spp) own = spp;
        fc = 1 + (q - 1) * gs;
        use_root = (q == gc) && ract;
        if (use_root && iid < rsh)
            owner = 0;
        else
        begin
            n = use_root ? iid - rsh : iid;
            p = (spp > 0) ? n / spp : gs - 1;
            if (p >= gs) p = gs - 1;
            owner = fc + p;
        end
        l.gs = gs[10:0];
        l.gc = gc[9:0];
        l.grp = grp[10:0];
        l.ract = ract;
        l.arank = ar[9:0];
        l.spp = spp[15:0];
        l.rsh = rsh[15:0];
        l.first = first[15:0];
        l.own = own[15:0];
        l.owner = owner[20:0];
        return l;
    endfunction

    task automatic check_field(string name, longint exp_val, longint act_val);
        if (exp_val != act_val)
        begin
            $display("%0t %s exp %0d got %0d", $time, name, exp_val, act_val);
            errors++;
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        layout_t e, a;
        if (rst_n && out_valid && out_ready)
        begin
            a = {group_size, group_count, group_number, root_active, active_rank,
                 items_per_worker, root_share, first_item, own_item_count, owner_rank};
            if (expected_layouts.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, a);
                errors++;
            end
            else
            begin
                e = expected_layouts.pop_front();
                check_field("group_size", longint'(e.gs), longint'(a.gs));
                check_field("group_count", longint'(e.gc), longint'(a.gc));
                check_field("group_number", longint'(e.grp), longint'(a.grp));
                check_field("root_active", longint'(e.ract), longint'(a.ract));
                check_field("active_rank", longint'(e.arank), longint'(a.arank));
                check_field("items_per_worker", longint'(e.spp), longint'(a.spp));
                check_field("root_share", longint'(e.rsh), longint'(a.rsh));
                check_field("first_item", longint'(e.first), longint'(a.first));
                check_field("own_item_count", longint'(e.own), longint'(a.own));
                check_field("owner_rank", longint'(e.owner), longint'(a.owner));
            end
        end
    end

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (hold_off) out_ready <= 1'b0;
        else if (!burst_mode) out_ready <= 1'b1;
        else out_ready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance with
    // in_valid still high, so the next call follows back to back
    task automatic send_query(logic [9:0] r, logic [10:0] qg, logic [15:0] id);
        worker_rank = r;
        query_group = qg;
        item_id     = id;
        in_valid    = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        expected_layouts.push_back(predict_layout(r, qg, id));
        @(negedge clk);
    endtask

    // random gaps split the stream into bursts
    task automatic send_random_query(bit gaps);
        logic [9:0]  r;
        logic [10:0] qg;
        logic [15:0] id;
        if (gaps && $urandom_range(0, 7) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        case ($urandom_range(0, 3))
            0:
            begin
                r  = 10'($urandom);
                qg = 11'($urandom);
                id = 16'($urandom);
            end
            default:
            begin
                r = 10'($urandom_range(0, 32'(sh_wc + 2)));
                if ($urandom_range(0, 3) == 0)
                    qg = 11'($urandom_range(0, 2047));
                else
                    qg = 11'($urandom_range(0, 32'(sh_wc + 1)));
                id = 16'($urandom_range(0, 32'(sh_items + 4)));
            end
        endcase
        send_query(r, qg, id);
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (expected_layouts.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            wprc_pkg::REG_ITEM_COUNT: sh_items = longint'(val);
            wprc_pkg::REG_THREADS:    sh_thr   = longint'(val & 16'h01FF);
            wprc_pkg::REG_ROOT_IDLE:  sh_idle  = longint'(val & 16'h0001);
            wprc_pkg::REG_WORKER_CNT: sh_wc    = longint'(val & 16'h07FF);
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(logic [15:0] it, logic [15:0] th, logic [15:0] idl,
                             logic [15:0] wc);
        wait_drained();
        write_reg(wprc_pkg::REG_ITEM_COUNT, it);
        write_reg(wprc_pkg::REG_THREADS, th);
        write_reg(wprc_pkg::REG_ROOT_IDLE, idl);
        write_reg(wprc_pkg::REG_WORKER_CNT, wc);
    endtask

    task automatic test_reset_defaults();
        send_query(10'd0, 11'd1, 16'd0);
        send_query(10'h3FF, 11'h7FF, 16'hFFFF);
        send_query(10'd1, 11'd0, 16'd1);
    endtask

    task automatic test_directed_extremes();
        configure(16'hFFFF, 16'd1, 16'd0, 16'd1024);
        send_query(10'd0, 11'd1, 16'd0);
        send_query(10'd1023, 11'd1023, 16'd65535);
        send_query(10'd512, 11'd0, 16'd100);
        configure(16'd0, 16'd0, 16'd1, 16'd0);     // zero items, zero threads, no workers
        send_query(10'd0, 11'd1, 16'd5);
        send_query(10'd3, 11'd2, 16'd0);
        configure(16'd100, 16'd256, 16'd1, 16'h7FF);  // worker count saturates
        send_query(10'd0, 11'd1023, 16'd99);
        send_query(10'd1023, 11'd2047, 16'd0);
        configure(16'd1000, 16'd3, 16'd0, 16'd17);
        for (int i = 0; i < 8; i++)
            send_query(10'(i * 3), 11'(i + 1), 16'(i * 70));
        configure(16'd40, 16'd4, 16'd1, 16'd9);
        send_query(10'd0, 11'd1, 16'd39);
        send_query(10'd8, 11'd2, 16'd12);
        send_query(10'd50, 11'd1, 16'd65535);   // rank past worker count
    endtask

    task automatic test_random_configs();
        for (int phase = 0; phase < 12; phase++)
        begin
            configure(($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(0, 2000)),
                      ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 511))
                                                  : 16'($urandom_range(1, 8)),
                      16'($urandom_range(0, 1)),
                      ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 2047))
                                                  : 16'($urandom_range(1, 40)));
            burst_mode = (phase % 3 != 2);
            for (int i = 0; i < 90; i++)
                send_random_query(burst_mode);
        end
    endtask

    task automatic test_backpressure();
        configure(16'd777, 16'd5, 16'd0, 16'd33);
        fork
            begin
                hold_off = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                for (int i = 0; i < 60; i++)
                    send_random_query(1'b0);
                in_valid = 1'b0;
            end
        join
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_directed_extremes();
        test_backpressure();
        test_random_configs();
        wait_drained();
        if (errors == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/wprc_pkg.sv
rtl/wprc_div_stage.sv
rtl/wprc_cfg_calc.sv
rtl/work_partition_rank_calc.sv
tb/tb_top.sv
